[rtl/audio_ring_rate_adjusting_resampler_defines.svh]
// Assertion macros shared by the resampler checker
`ifndef AUDIO_RING_RATE_ADJUSTING_RESAMPLER_DEFINES_SVH
`define AUDIO_RING_RATE_ADJUSTING_RESAMPLER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define ARR_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("resampler check failed");

// Next-cycle implication, sampled on clk, off during reset
`define ARR_CHECK_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("resampler check failed");

`endif

[rtl/arr_pkg.sv]
// Shared types, constants and helpers for the audio ring resampler
package arr_pkg;

    localparam int RING_DEPTH = 4096;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int LEN_W      = PTR_W + 1;
    localparam int MAX_COPIES = 24;
    localparam int COPY_W     = 5;
    localparam int FILL_W     = 12;
    localparam int SAMPLE_W   = 16;
    localparam int FRAME_W    = 2 * SAMPLE_W;
    localparam int MODE_W     = 2;
    localparam int RATE_W     = 18;
    localparam int ADJ_W      = 10;
    localparam int PHASE_W    = 20;
    localparam int LEVEL_W    = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int LOW_PCT    = 40;
    localparam int HIGH_PCT   = 60;
    localparam int PCT_SCALE  = 100;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = QPTR_W + 1;

    localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

    localparam logic [MODE_W-1:0] MODE_PASS      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NEAREST   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RATE_CTRL = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE        = 3'd0,
        REG_INPUT_RATE  = 3'd1,
        REG_OUTPUT_RATE = 3'd2,
        REG_RATE_ADJUST = 3'd3,
        REG_RING_LENGTH = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_POP,
        KIND_PASS,
        KIND_NEAREST,
        KIND_RATE_CTRL
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEVEL,
        ST_ADJUST,
        ST_COPY,
        ST_FINISH
    } state_t;

    typedef struct packed {
        kind_t                       kind;
        logic signed [SAMPLE_W-1:0]  left;
        logic signed [SAMPLE_W-1:0]  right;
    } item_t;

    typedef struct packed {
        logic                   valid;
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_wr_t;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p,
                                                  input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] inc;
        inc = {1'b0, p} + LEN_W'(1);
        return (inc >= len) ? '0 : inc[PTR_W-1:0];
    endfunction

endpackage

[rtl/arr_front.sv]
// Front end: accept a command word, classify it by mode, hand it to the queue
module arr_front
    import arr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       operation,
    input  logic signed [SAMPLE_W-1:0] in_left,
    input  logic signed [SAMPLE_W-1:0] in_right,
    input  logic [MODE_W-1:0]          mode,
    input  logic                       q_full,
    output logic                       busy,
    output logic                       q_push,
    output item_t                      q_item
);

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;
    kind_t kind;
    logic  accept;

    always_comb
    begin
        if (operation)
            kind = KIND_POP;
        else if (mode == MODE_PASS)
            kind = KIND_PASS;
        else if (mode == MODE_RATE_CTRL)
            kind = KIND_RATE_CTRL;
        else
            kind = KIND_NEAREST;
    end

    assign q_push = valid_reg && !q_full;
    assign busy   = valid_reg && q_full;
    assign accept = start && !busy;
    assign q_item = item_reg;

    always_comb
    begin
        valid_next = valid_reg && !q_push;
        item_next  = item_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            item_next  = '{kind: kind, left: in_left, right: in_right};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

[rtl/arr_queue.sv]
// Short queue of classified words between front and back end
module arr_queue
    import arr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head,
    output logic  empty,
    output logic  full
);

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head    = slot_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_next  = do_push ? QPTR_W'(wr_reg + 1'b1) : wr_reg;
        rd_next  = do_pop ? QPTR_W'(rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= push_item;
    end

endmodule

[rtl/arr_back.sv]
// Back end: configuration registers, ring memory and the push/pop sequencer
module arr_back
    import arr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_wr_t                    cfg,
    input  logic                       q_empty,
    input  item_t                      q_head,
    output logic                       q_pop,
    output logic [MODE_W-1:0]          mode,
    output logic                       done,
    output logic signed [SAMPLE_W-1:0] out_left,
    output logic signed [SAMPLE_W-1:0] out_right,
    output logic                       frame_valid,
    output logic [COPY_W-1:0]          copies_written,
    output logic                       overflow,
    output logic [FILL_W-1:0]          fill_count
);

    state_t             state_reg, state_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [RATE_W-1:0]  in_rate_reg, in_rate_next;
    logic [RATE_W-1:0]  out_rate_reg, out_rate_next;
    logic [ADJ_W-1:0]   rate_adj_reg, rate_adj_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic [PTR_W-1:0]   lrp_reg, lrp_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [RATE_W-1:0]  adj_rate_reg, adj_rate_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [COPY_W-1:0]  copies_reg, copies_next;
    logic               ovf_reg, ovf_next;
    logic               valid_reg, valid_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [LEVEL_W-1:0] lo_reg, lo_next;
    logic [LEVEL_W-1:0] hi_reg, hi_next;

    logic                       done_reg;
    logic signed [SAMPLE_W-1:0] out_left_reg, out_right_reg;
    logic                       out_valid_reg, out_ovf_reg;
    logic [COPY_W-1:0]          out_copies_reg;
    logic [FILL_W-1:0]          out_fill_reg;
    logic                       finish;

    logic [FRAME_W-1:0] ring [RING_DEPTH];
    logic [FRAME_W-1:0] rd_data_reg;
    logic               mem_we, mem_re;
    logic [FRAME_W-1:0] mem_wdata;

    logic [LEN_W-1:0]   fill_full;
    logic [RATE_W:0]    rate_sum;
    logic [PHASE_W-1:0] phase_step;
    logic [PHASE_W-1:0] adj_ext;
    logic [LEN_W-1:0]   len_raw;
    logic [LEN_W-1:0]   len_clamped;

    assign mode = mode_reg;

    always_comb
    begin
        if (wp_reg >= rp_reg)
            fill_full = {1'b0, wp_reg} - {1'b0, rp_reg};
        else
            fill_full = {1'b0, wp_reg} + len_reg - {1'b0, rp_reg};
    end

    assign rate_sum   = {1'b0, out_rate_reg} + (RATE_W + 1)'(rate_adj_reg);
    assign phase_step = phase_reg + PHASE_W'(in_rate_reg);
    assign adj_ext    = PHASE_W'(adj_rate_reg);
    assign len_raw    = cfg.data[LEN_W-1:0];

    always_comb
    begin
        if (len_raw < LEN_W'(2))
            len_clamped = LEN_W'(2);
        else if (len_raw > LEN_W'(RING_DEPTH))
            len_clamped = LEN_W'(RING_DEPTH);
        else
            len_clamped = len_raw;
    end

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        in_rate_next  = in_rate_reg;
        out_rate_next = out_rate_reg;
        rate_adj_next = rate_adj_reg;
        len_next      = len_reg;
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        lrp_next      = lrp_reg;
        phase_next    = phase_reg;
        adj_rate_next = adj_rate_reg;
        frame_next    = frame_reg;
        copies_next   = copies_reg;
        ovf_next      = ovf_reg;
        valid_next    = valid_reg;
        level_next    = level_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_wdata     = frame_reg;
        finish        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop       = 1'b1;
                    frame_next  = {q_head.left, q_head.right};
                    copies_next = '0;
                    ovf_next    = 1'b0;
                    valid_next  = 1'b0;
                    unique case (q_head.kind)
                        KIND_POP:
                        begin
                            state_next = ST_FINISH;
                            if (rp_reg != wp_reg)
                            begin
                                mem_re     = 1'b1;
                                valid_next = 1'b1;
                                lrp_next   = rp_reg;
                                rp_next    = next_ptr(rp_reg, len_reg);
                            end
                        end
                        KIND_PASS:
                        begin
                            state_next = ST_FINISH;
                            if (wp_reg == lrp_reg)
                                ovf_next = 1'b1;
                            else
                            begin
                                mem_we      = 1'b1;
                                mem_wdata   = {q_head.left, q_head.right};
                                copies_next = COPY_W'(1);
                                wp_next     = next_ptr(wp_reg, len_reg);
                            end
                        end
                        KIND_RATE_CTRL: state_next = ST_LEVEL;
                        KIND_NEAREST:   state_next = ST_COPY;
                        default:        state_next = ST_FINISH;
                    endcase
                end
            end
            ST_LEVEL:
            begin
                // fill*100 against 40*len and 61*len
                level_next = LEVEL_W'(fill_full) * LEVEL_W'(PCT_SCALE);
                lo_next    = LEVEL_W'(len_reg) * LEVEL_W'(LOW_PCT);
                hi_next    = LEVEL_W'(len_reg) * LEVEL_W'(HIGH_PCT + 1);
                state_next = ST_ADJUST;
            end
            ST_ADJUST:
            begin
                if (level_reg < lo_reg)
                    adj_rate_next = rate_sum[RATE_W] ? RATE_MAX : rate_sum[RATE_W-1:0];
                else if (level_reg >= hi_reg)
                    adj_rate_next = (out_rate_reg > RATE_W'(rate_adj_reg)) ?
                                    out_rate_reg - RATE_W'(rate_adj_reg) : '0;
                else
                    adj_rate_next = out_rate_reg;
                state_next = ST_COPY;
            end
            ST_COPY:
            begin
                // one step of the nearest-neighbour loop per cycle
                if (wp_reg == lrp_reg)
                begin
                    ovf_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (phase_reg < adj_ext)
                begin
                    if (copies_reg >= COPY_W'(MAX_COPIES))
                        state_next = ST_FINISH;
                    else
                    begin
                        mem_we      = 1'b1;
                        copies_next = copies_reg + COPY_W'(1);
                        wp_next     = next_ptr(wp_reg, len_reg);
                        if (phase_step >= adj_ext)
                        begin
                            phase_next = phase_step - adj_ext;
                            state_next = ST_FINISH;
                        end
                        else
                            phase_next = phase_step;
                    end
                end
                else
                begin
                    phase_next = phase_reg - adj_ext;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                finish     = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase

        if (cfg.valid)
        begin
            case (cfg.index)
                REG_MODE:        mode_next = cfg.data[MODE_W-1:0];
                REG_INPUT_RATE:  in_rate_next = cfg.data[RATE_W-1:0];
                REG_OUTPUT_RATE:
                begin
                    out_rate_next = cfg.data[RATE_W-1:0];
                    adj_rate_next = cfg.data[RATE_W-1:0];
                end
                REG_RATE_ADJUST: rate_adj_next = cfg.data[ADJ_W-1:0];
                REG_RING_LENGTH:
                begin
                    len_next = len_clamped;
                    wp_next  = '0;
                    rp_next  = '0;
                    lrp_next = PTR_W'(len_clamped - LEN_W'(1));
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_NEAREST;
            in_rate_reg  <= RATE_W'(44100);
            out_rate_reg <= RATE_W'(48000);
            rate_adj_reg <= ADJ_W'(144);
            len_reg      <= LEN_W'(RING_DEPTH);
            wp_reg       <= '0;
            rp_reg       <= '0;
            lrp_reg      <= PTR_W'(RING_DEPTH - 1);
            phase_reg    <= '0;
            adj_rate_reg <= RATE_W'(48000);
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            in_rate_reg  <= in_rate_next;
            out_rate_reg <= out_rate_next;
            rate_adj_reg <= rate_adj_next;
            len_reg      <= len_next;
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            lrp_reg      <= lrp_next;
            phase_reg    <= phase_next;
            adj_rate_reg <= adj_rate_next;
            done_reg     <= finish;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg  <= frame_next;
        copies_reg <= copies_next;
        ovf_reg    <= ovf_next;
        valid_reg  <= valid_next;
        level_reg  <= level_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        if (finish)
        begin
            out_left_reg   <= valid_reg ? rd_data_reg[FRAME_W-1:SAMPLE_W] : '0;
            out_right_reg  <= valid_reg ? rd_data_reg[SAMPLE_W-1:0] : '0;
            out_valid_reg  <= valid_reg;
            out_copies_reg <= copies_reg;
            out_ovf_reg    <= ovf_reg;
            out_fill_reg   <= fill_full[FILL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring[wp_reg] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= ring[rp_reg];
    end

    assign done           = done_reg;
    assign out_left       = out_left_reg;
    assign out_right      = out_right_reg;
    assign frame_valid    = out_valid_reg;
    assign copies_written = out_copies_reg;
    assign overflow       = out_ovf_reg;
    assign fill_count     = out_fill_reg;

endmodule

[rtl/audio_ring_rate_adjusting_resampler.sv]
// Done is registered from the back end's finish state; results cannot be stalled.
// The back-end sequencer finishes each word before it pops the next from the queue.
// A resampling push walks the copy loop (one ring write per copy, up to 24),
// preceded in rate-control mode by fill-level evaluation in the level and
// adjust states. A pop or passthrough push goes from idle straight to finish.
// Reset: asynchronous, clears queue and pointers, registers take their defaults.
module audio_ring_rate_adjusting_resampler
    import arr_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         operation,
    input  logic signed [SAMPLE_W-1:0]   in_left,
    input  logic signed [SAMPLE_W-1:0]   in_right,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    output logic                         done,
    output logic signed [SAMPLE_W-1:0]   out_left,
    output logic signed [SAMPLE_W-1:0]   out_right,
    output logic                         frame_valid,
    output logic [COPY_W-1:0]            copies_written,
    output logic                         overflow,
    output logic [FILL_W-1:0]            fill_count
);

    logic              q_push, q_pop, q_empty, q_full;
    item_t             q_in, q_head;
    logic [MODE_W-1:0] mode;
    cfg_wr_t           cfg;

    assign cfg_ready = 1'b1;
    assign cfg       = '{valid: cfg_valid, index: cfg_index, data: cfg_data};

    arr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .in_left   (in_left),
        .in_right  (in_right),
        .mode      (mode),
        .q_full    (q_full),
        .busy      (busy),
        .q_push    (q_push),
        .q_item    (q_in)
    );

    arr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    arr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .mode           (mode),
        .done           (done),
        .out_left       (out_left),
        .out_right      (out_right),
        .frame_valid    (frame_valid),
        .copies_written (copies_written),
        .overflow       (overflow),
        .fill_count     (fill_count)
    );

endmodule

[rtl/arr_checker.sv]
// Port-level checker for the resampler, bound to the top level
`include "audio_ring_rate_adjusting_resampler_defines.svh"

module arr_checker
    import arr_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       done,
    input logic signed [SAMPLE_W-1:0] out_left,
    input logic signed [SAMPLE_W-1:0] out_right,
    input logic                       frame_valid,
    input logic [COPY_W-1:0]          copies_written,
    input logic                       overflow
);

    `ARR_CHECK_NXT(a_done_spaced, done, !done)
    `ARR_CHECK(a_pop_no_push_fields, done && frame_valid, (copies_written == '0) && !overflow)
    `ARR_CHECK(a_silence_zero, done && !frame_valid, (out_left == '0) && (out_right == '0))
    `ARR_CHECK(a_copy_limit, done, copies_written <= COPY_W'(MAX_COPIES))

endmodule

bind audio_ring_rate_adjusting_resampler arr_checker u_arr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .done           (done),
    .out_left       (out_left),
    .out_right      (out_right),
    .frame_valid    (frame_valid),
    .copies_written (copies_written),
    .overflow       (overflow)
);

[tb/sv/audio_ring_rate_adjusting_resampler_tb.sv]
// Self-checking bench for the audio ring resampler: mirrored ring state, push/pop traffic, register sweeps
module audio_ring_rate_adjusting_resampler_tb;
    import arr_pkg::*;

    localparam int ITEM_TARGET   = 1450;
    localparam int QUIET_TAIL    = 150;
    localparam int SETTLE_CYCLES = 40;
    localparam int SHOW_LIMIT    = 10;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [MODE_W-1:0]    MODE_ALIAS = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 3'd7;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       valid;
        logic [COPY_W-1:0]          copies;
        logic                       ovf;
        logic [FILL_W-1:0]          fill;
    } ring_reply_t;

    // Tracks ring contents, pointers, phase and registers; queues the reply each word earns
    class ring_mirror;
        logic [FRAME_W-1:0] ring [RING_DEPTH];
        int unsigned wr_ptr, rd_ptr, last_rd, span;
        int unsigned phase, adj_rate;
        logic [MODE_W-1:0] mode_reg;
        int unsigned in_rate, out_rate, adj_step, len_reg;
        ring_reply_t owed[$];
        int errors, shown;
        int pushes, pops, empty_pops, copies_total, full_hits, limit_hits;
        int low_fill, high_fill;

        function new();
            mode_reg = MODE_NEAREST;
            in_rate  = 44100;
            out_rate = 48000;
            adj_step = 144;
            len_reg  = RING_DEPTH;
            phase    = 0;
            adj_rate = out_rate;
            restart_ring();
        endfunction

        function void restart_ring();
            span    = (len_reg < 2) ? 2 : (len_reg > RING_DEPTH) ? RING_DEPTH : len_reg;
            wr_ptr  = 0;
            rd_ptr  = 0;
            last_rd = span - 1;
        endfunction

        function int unsigned level();
            return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : wr_ptr + span - rd_ptr;
        endfunction

        function int unsigned advance(input int unsigned p);
            return (p + 1 >= span) ? 0 : p + 1;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MODE:        mode_reg = data[MODE_W-1:0];
                REG_INPUT_RATE:  in_rate = data[RATE_W-1:0];
                REG_OUTPUT_RATE:
                begin
                    out_rate = data[RATE_W-1:0];
                    adj_rate = out_rate;
                end
                REG_RATE_ADJUST: adj_step = data[ADJ_W-1:0];
                REG_RING_LENGTH:
                begin
                    len_reg = data[LEN_W-1:0];
                    restart_ring();
                end
                default: ;
            endcase
        endfunction

        function void take_item(input logic op, input logic signed [SAMPLE_W-1:0] l,
                                input logic signed [SAMPLE_W-1:0] r);
            ring_reply_t want;
            logic [FRAME_W-1:0] frame;
            int unsigned copies, scaled, sum;
            want   = '0;
            copies = 0;
            if (op == OP_POP) begin
                pops++;
                if (rd_ptr != wr_ptr) begin
                    frame      = ring[rd_ptr];
                    want.left  = frame[FRAME_W-1:SAMPLE_W];
                    want.right = frame[SAMPLE_W-1:0];
                    want.valid = 1'b1;
                    last_rd    = rd_ptr;
                    rd_ptr     = advance(rd_ptr);
                end else begin
                    empty_pops++;
                end
            end else begin
                pushes++;
                frame = {l, r};
                if (mode_reg == MODE_PASS) begin
                    if (wr_ptr == last_rd) begin
                        want.ovf = 1'b1;
                    end else begin
                        ring[wr_ptr] = frame;
                        wr_ptr = advance(wr_ptr);
                        copies = 1;
                    end
                end else begin
                    if (mode_reg == MODE_RATE_CTRL) begin
                        scaled = level() * PCT_SCALE;
                        if (scaled < LOW_PCT * span) begin
                            sum = out_rate + adj_step;
                            adj_rate = (sum > RATE_MAX) ? RATE_MAX : sum;
                            low_fill++;
                        end else if (scaled >= (HIGH_PCT + 1) * span) begin
                            adj_rate = (out_rate > adj_step) ? out_rate - adj_step : 0;
                            high_fill++;
                        end else begin
                            adj_rate = out_rate;
                        end
                    end
                    forever begin
                        if (wr_ptr == last_rd) begin
                            want.ovf = 1'b1;
                            break;
                        end
                        if (phase < adj_rate) begin
                            if (copies >= MAX_COPIES) begin
                                limit_hits++;
                                break;
                            end
                            ring[wr_ptr] = frame;
                            wr_ptr = advance(wr_ptr);
                            copies++;
                            phase = (phase + in_rate) & ((1 << PHASE_W) - 1);
                        end
                        if (phase >= adj_rate) begin
                            phase -= adj_rate;
                            break;
                        end
                    end
                end
                if (want.ovf)
                    full_hits++;
                copies_total += copies;
            end
            want.copies = COPY_W'(copies);
            want.fill   = FILL_W'(level());
            owed.push_back(want);
        endfunction

        function void match_result(input ring_reply_t got);
            ring_reply_t want;
            if (owed.size() == 0) begin
                errors++;
                if (shown++ < SHOW_LIMIT)
                    $display("%0t: result with nothing pending: L=%0d R=%0d V=%0b N=%0d OV=%0b F=%0d",
                             $time, got.left, got.right, got.valid, got.copies, got.ovf, got.fill);
                return;
            end
            want = owed.pop_front();
            if (got.left !== want.left || got.right !== want.right ||
                got.valid !== want.valid || got.copies !== want.copies ||
                got.ovf !== want.ovf || got.fill !== want.fill) begin
                errors++;
                if (shown++ < SHOW_LIMIT) begin
                    $display("%0t: mismatch, expected L=%0d R=%0d V=%0b N=%0d OV=%0b F=%0d",
                             $time, want.left, want.right, want.valid, want.copies,
                             want.ovf, want.fill);
                    $display("%0t:            actual   L=%0d R=%0d V=%0b N=%0d OV=%0b F=%0d",
                             $time, got.left, got.right, got.valid, got.copies,
                             got.ovf, got.fill);
                end
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic                       operation;
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       done;
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       frame_valid;
    logic [COPY_W-1:0]          copies_written;
    logic                       overflow;
    logic [FILL_W-1:0]          fill_count;

    ring_mirror mirror = new();
    int  items_sent;
    int  reg_writes;
    int  settings;
    bit  quiet;

    audio_ring_rate_adjusting_resampler u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .in_left        (in_left),
        .in_right       (in_right),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .out_left       (out_left),
        .out_right      (out_right),
        .frame_valid    (frame_valid),
        .copies_written (copies_written),
        .overflow       (overflow),
        .fill_count     (fill_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            mirror.match_result('{out_left, out_right, frame_valid, copies_written,
                                  overflow, fill_count});
    end

    task automatic ring_op(input logic op, input logic signed [SAMPLE_W-1:0] l,
                           input logic signed [SAMPLE_W-1:0] r);
        start     <= 1'b1;
        operation <= op;
        in_left   <= l;
        in_right  <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        mirror.take_item(op, l, r);
        items_sent++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10))
                @(posedge clk);
        end
    endtask

    // Hold the sender until every pending word has come back
    task automatic settle_ring();
        start <= 1'b0;
        do
            @(posedge clk);
        while (mirror.owed.size() != 0);
    endtask

    // Leaves valid high so back-to-back writes need no dip; caller drops it
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mirror.write_reg(idx, data);
        reg_writes++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_rate();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return CFG_DATA_W'(8000);
            2:       return CFG_DATA_W'(192000);
            3:       return RATE_MAX;
            default: return CFG_DATA_W'($urandom_range(8000, 192000));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_length();
        case ($urandom_range(0, 15))
            0:       return CFG_DATA_W'($urandom_range(0, 8191));
            1, 2:    return CFG_DATA_W'($urandom_range(49, 600));
            default: return CFG_DATA_W'($urandom_range(2, 48));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_mode();
        case ($urandom_range(0, 9))
            0:       return CFG_DATA_W'(MODE_PASS);
            1:       return CFG_DATA_W'(MODE_ALIAS);
            2, 3, 4: return CFG_DATA_W'(MODE_NEAREST);
            default: return CFG_DATA_W'(MODE_RATE_CTRL);
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return S_MIN;
            1:       return S_MAX;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int   random_end;
        int   run_left;
        int   push_pct;
        logic run_op;

        start     = 1'b0;
        operation = OP_PUSH;
        in_left   = '0;
        in_right  = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: empty pop, sample extremes, drain back out
        ring_op(OP_POP, '0, '0);
        ring_op(OP_PUSH, S_MAX, S_MIN);
        ring_op(OP_PUSH, S_MIN, S_MAX);
        ring_op(OP_PUSH, '0, -16'sd1);
        ring_op(OP_PUSH, -16'sd1, '0);
        repeat (5)
            ring_op(OP_POP, '0, '0);

        // Passthrough on the shortest ring: second push hits a full ring
        settle_ring();
        cfg_write(REG_MODE, 18'h3FFFC);
        cfg_write(REG_RING_LENGTH, '0);
        cfg_valid <= 1'b0;
        ring_op(OP_PUSH, S_MAX, S_MAX);
        ring_op(OP_PUSH, S_MIN, S_MIN);
        ring_op(OP_POP, '0, '0);
        ring_op(OP_POP, '0, '0);

        // Undefined mode, strong upsampling: copy limit; oversized length clamps
        settle_ring();
        cfg_write(REG_MODE, CFG_DATA_W'(MODE_ALIAS));
        cfg_write(REG_INPUT_RATE, CFG_DATA_W'(8000));
        cfg_write(REG_OUTPUT_RATE, CFG_DATA_W'(192000));
        cfg_write(REG_SPARE, 18'h2AAAA);
        cfg_write(REG_RING_LENGTH, CFG_DATA_W'(8191));
        cfg_valid <= 1'b0;
        ring_op(OP_PUSH, 16'sh1234, -16'sh1234);
        ring_op(OP_POP, '0, '0);

        // Zero input rate, then zero output rate
        settle_ring();
        cfg_write(REG_INPUT_RATE, '0);
        cfg_valid <= 1'b0;
        ring_op(OP_PUSH, 16'sh5555, 16'shAAAA);
        settle_ring();
        cfg_write(REG_OUTPUT_RATE, '0);
        cfg_valid <= 1'b0;
        ring_op(OP_PUSH, 16'shAAAA, 16'sh5555);

        // Rate control on a short ring: saturate upward, fill up, then clamp to zero
        settle_ring();
        cfg_write(REG_MODE, CFG_DATA_W'(MODE_RATE_CTRL));
        cfg_write(REG_RING_LENGTH, CFG_DATA_W'(10));
        cfg_write(REG_INPUT_RATE, CFG_DATA_W'(48000));
        cfg_write(REG_OUTPUT_RATE, RATE_MAX);
        cfg_write(REG_RATE_ADJUST, 18'h3FFFF);
        cfg_valid <= 1'b0;
        repeat (3)
            ring_op(OP_PUSH, pick_sample(), pick_sample());
        ring_op(OP_POP, '0, '0);
        ring_op(OP_POP, '0, '0);
        settle_ring();
        cfg_write(REG_OUTPUT_RATE, CFG_DATA_W'(500));
        cfg_write(REG_RATE_ADJUST, CFG_DATA_W'(1000));
        cfg_valid <= 1'b0;
        ring_op(OP_PUSH, pick_sample(), pick_sample());

        // Random settings, each followed by push and pop runs that sweep the fill level
        random_end = items_sent + ITEM_TARGET;
        while (items_sent < random_end) begin
            settle_ring();
            if ($urandom_range(0, 9) < 7)
                cfg_write(REG_MODE, pick_mode());
            if ($urandom_range(0, 9) < 7)
                cfg_write(REG_INPUT_RATE, pick_rate());
            if ($urandom_range(0, 9) < 7)
                cfg_write(REG_OUTPUT_RATE, pick_rate());
            if ($urandom_range(0, 9) < 7)
                cfg_write(REG_RATE_ADJUST, ($urandom_range(0, 15) == 0) ?
                          18'h3FFFF : CFG_DATA_W'($urandom_range(0, 1000)));
            if ($urandom_range(0, 9) < 7)
                cfg_write(REG_RING_LENGTH, pick_length());
            if ($urandom_range(0, 19) == 0)
                cfg_write(REG_SPARE, CFG_DATA_W'($urandom));
            cfg_valid <= 1'b0;
            settings++;
            push_pct = $urandom_range(25, 75);
            run_left = 0;
            repeat ($urandom_range(30, 120)) begin
                quiet = (items_sent >= random_end - QUIET_TAIL);
                if (run_left == 0) begin
                    run_op   = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
                    run_left = $urandom_range(1, 12);
                end
                run_left--;
                if (!quiet && $urandom_range(0, 49) == 0)
                    settle_ring();
                ring_op(run_op, pick_sample(), pick_sample());
            end
        end

        settle_ring();
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("Covered %0d pushes (%0d copies, %0d full-ring drops, %0d capped), %0d pops (%0d empty)",
                 mirror.pushes, mirror.copies_total, mirror.full_hits, mirror.limit_hits,
                 mirror.pops, mirror.empty_pops);
        $display("%0d register writes over %0d random settings, rate control low/high fill: %0d/%0d",
                 reg_writes, settings, mirror.low_fill, mirror.high_fill);
        if (mirror.owed.size() != 0)
            $display("%0d expected results never arrived", mirror.owed.size());
        if (mirror.errors == 0 && mirror.owed.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
